// ===== sv/homography_inlier_scoring_core_defines.svh =====
// Assertion macros used by the port-level checker of the inlier scoring core.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef HOMOGRAPHY_INLIER_SCORING_CORE_DEFINES_SVH
`define HOMOGRAPHY_INLIER_SCORING_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HISC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hisc check failed");

// Next-cycle implication, checked outside reset.
`define HISC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hisc check failed");

`endif

// ===== sv/hisc_pkg.sv =====
// Package of the homography inlier scoring core: command and status types and constants.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package hisc_pkg;

    localparam int unsigned NumCoef   = 9;
    localparam int unsigned CountW    = 16;
    localparam int unsigned QuotW     = 25;
    localparam logic [24:0] ProjPosMax = 25'd8388607;
    localparam logic [24:0] ProjNegMax = 25'd8388608;
    localparam logic        OpLoad     = 1'b0;
    localparam logic        OpTest     = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       acc_clr;
        logic       mul_en;
        logic [3:0] mul_idx;
        logic       div_start;
        logic       div_sel;
        logic       sq_en;
        logic       sq_sel;
        logic       finish_load;
        logic       finish_test;
    } hisc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic w_zero;
        logic out_full;
    } hisc_sts_t;

    function automatic logic [63:0] hisc_mag(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

endpackage

`default_nettype wire

// ===== sv/hisc_ctrl.sv =====
// Controller of the inlier scoring core: sequences products, divisions and the final result.
// Depends on hisc_pkg.
`default_nettype none

module hisc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              operation,
    input  wire hisc_pkg::hisc_sts_t sts,
    output hisc_pkg::hisc_cmd_t    cmd
);
    import hisc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_WAITX = 4'd5;
    localparam logic [3:0] S_SQX   = 4'd6;
    localparam logic [3:0] S_WAITY = 4'd7;
    localparam logic [3:0] S_SQY   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            op_reg    <= OpLoad;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mul_idx = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = operation;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                cnt_next = '0;
                if (op_reg == OpLoad)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.acc_clr = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cnt_next   = cnt_reg + 4'd1;
                if (cnt_reg == 4'(NumCoef - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.w_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b0;
                    state_next    = S_WAITX;
                end
            end
            S_WAITX:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                cmd.sq_en     = 1'b1;
                cmd.sq_sel    = 1'b0;
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_WAITY;
            end
            S_WAITY:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                cmd.sq_en  = 1'b1;
                cmd.sq_sel = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!sts.out_full)
                begin
                    cmd.finish_load = (op_reg == OpLoad);
                    cmd.finish_test = (op_reg == OpTest);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/hisc_datapath.sv =====
// Datapath of the inlier scoring core: coefficient store, shared multiplier, accumulators,
// iterative divider, squared error and output register. Depends on hisc_pkg.
`default_nettype none

module hisc_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hisc_pkg::hisc_cmd_t cmd,
    output hisc_pkg::hisc_sts_t      sts,
    input  wire logic                cfg_we,
    input  wire logic [47:0]         cfg_wdata,
    input  wire logic [3:0]          coefficient_index,
    input  wire logic signed [47:0]  coefficient_value,
    input  wire logic signed [23:0]  src_x,
    input  wire logic signed [23:0]  src_y,
    input  wire logic signed [23:0]  dst_x,
    input  wire logic signed [23:0]  dst_y,
    input  wire logic                last_pair,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     is_inlier,
    output logic [15:0]              inlier_count,
    output logic                     degenerate,
    output logic                     count_final
);
    import hisc_pkg::*;

    logic [47:0]        tol_reg;
    logic [47:0]        coef_reg [NumCoef];
    logic [3:0]         idx_reg;
    logic [47:0]        val_reg;
    logic signed [23:0] sx_reg, sy_reg, dx_reg, dy_reg;
    logic               last_reg;

    logic signed [62:0] prod_reg;
    logic               prod_vld_reg;
    logic [1:0]         row_reg;
    logic signed [63:0] acc_reg [3];

    logic [63:0]        rem_reg, md_reg;
    logic [24:0]        lo_reg, q_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg, neg_reg, sat_reg;

    logic [49:0]        sum_reg;
    logic [15:0]        count_reg, count_next;
    logic               out_valid_reg, inl_reg, degen_reg, final_reg;

    logic signed [38:0] coef_q;
    logic signed [23:0] mul_op;
    logic [1:0]         row_c;
    logic signed [62:0] prod_c;
    logic [63:0]        mn, md;
    logic signed [63:0] num;
    logic [64:0]        trial;
    logic [24:0]        mag_lim;
    logic signed [23:0] proj;
    logic signed [23:0] dsel;
    logic signed [24:0] err;
    logic signed [49:0] sq;
    logic               inl_c;

    assign coef_q = $signed(coef_reg[cmd.mul_idx][47:9]);

    always_comb
    begin
        unique case (cmd.mul_idx)
            4'd0, 4'd3, 4'd6: mul_op = sx_reg;
            4'd1, 4'd4, 4'd7: mul_op = sy_reg;
            default:          mul_op = 24'sd256;
        endcase
        unique case (cmd.mul_idx)
            4'd0, 4'd1, 4'd2: row_c = 2'd0;
            4'd3, 4'd4, 4'd5: row_c = 2'd1;
            default:          row_c = 2'd2;
        endcase
    end

    assign prod_c = coef_q * mul_op;
    assign num    = cmd.div_sel ? acc_reg[1] : acc_reg[0];
    assign mn     = hisc_mag(num);
    assign md     = hisc_mag(acc_reg[2]);
    assign trial  = {rem_reg, lo_reg[QuotW-1]};

    always_comb
    begin
        if (neg_reg)
        begin
            mag_lim = (sat_reg || q_reg > ProjNegMax) ? ProjNegMax : q_reg;
            proj    = 24'(-mag_lim);
        end
        else
        begin
            mag_lim = (sat_reg || q_reg > ProjPosMax) ? ProjPosMax : q_reg;
            proj    = 24'(mag_lim);
        end
    end

    assign dsel  = cmd.sq_sel ? dy_reg : dx_reg;
    assign err   = 25'(proj) - 25'(dsel);
    assign sq    = err * err;
    assign inl_c = !sts.w_zero && (sum_reg <= {2'b00, tol_reg});

    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish_load)
        begin
            count_next = '0;
        end
        else if (cmd.finish_test && inl_c && count_reg != '1)
        begin
            count_next = count_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= '0;
            for (int i = 0; i < NumCoef; i++)
            begin
                coef_reg[i] <= '0;
            end
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            prod_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (cmd.finish_load && idx_reg < 4'(NumCoef))
            begin
                coef_reg[idx_reg] <= val_reg;
            end
            count_reg    <= count_next;
            prod_vld_reg <= cmd.mul_en;
            if (cmd.finish_load || cmd.finish_test)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.div_start)
            begin
                busy_reg <= ((mn >> 17) < md);
            end
            else if (busy_reg && cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= coefficient_index;
            val_reg  <= coefficient_value;
            sx_reg   <= src_x;
            sy_reg   <= src_y;
            dx_reg   <= dst_x;
            dy_reg   <= dst_y;
            last_reg <= last_pair;
        end
        prod_reg <= prod_c;
        row_reg  <= row_c;
        if (cmd.acc_clr)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (prod_vld_reg)
        begin
            acc_reg[row_reg] <= acc_reg[row_reg] + 64'(prod_reg);
        end
        if (cmd.div_start)
        begin
            neg_reg <= num[63] ^ acc_reg[2][63];
            md_reg  <= md;
            sat_reg <= ((mn >> 17) >= md);
            rem_reg <= mn >> 17;
            lo_reg  <= {mn[16:0], 8'd0};
            q_reg   <= '0;
            cnt_reg <= 5'(QuotW);
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, md_reg})
            begin
                rem_reg <= 64'(trial - {1'b0, md_reg});
                q_reg   <= {q_reg[QuotW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[63:0];
                q_reg   <= {q_reg[QuotW-2:0], 1'b0};
            end
            lo_reg  <= {lo_reg[QuotW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 5'd1;
        end
        if (cmd.sq_en)
        begin
            sum_reg <= cmd.sq_sel ? sum_reg + 50'(sq) : 50'(sq);
        end
        if (cmd.finish_load)
        begin
            inl_reg   <= 1'b0;
            degen_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else if (cmd.finish_test)
        begin
            inl_reg   <= inl_c;
            degen_reg <= sts.w_zero;
            final_reg <= last_reg;
        end
    end

    assign sts.div_busy = busy_reg;
    assign sts.w_zero   = (acc_reg[2] == '0);
    assign sts.out_full = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign is_inlier    = inl_reg;
    assign inlier_count = count_reg;
    assign degenerate   = degen_reg;
    assign count_final  = final_reg;

endmodule

`default_nettype wire

// ===== sv/homography_inlier_scoring_core.sv =====
// Homography inlier scoring core: top level joining hisc_ctrl and hisc_datapath, uses hisc_pkg.
// A load item passes through decode to finish; a test item runs nine passes of the shared
// multiplier and two 25-step divisions. A new item is taken only when the last one is done.
// A zero w ends a test without dividing, a saturating quotient skips its 25 steps, and a result
// that waits on out_ready holds the next item off. Reset is asynchronous and active low; it
// clears the coefficients, the tolerance, the count and all control state.
`default_nettype none

module homography_inlier_scoring_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [47:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               operation,
    input  wire logic [3:0]         coefficient_index,
    input  wire logic signed [47:0] coefficient_value,
    input  wire logic signed [23:0] src_x,
    input  wire logic signed [23:0] src_y,
    input  wire logic signed [23:0] dst_x,
    input  wire logic signed [23:0] dst_y,
    input  wire logic               last_pair,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    is_inlier,
    output logic [15:0]             inlier_count,
    output logic                    degenerate,
    output logic                    count_final
);
    import hisc_pkg::*;

    hisc_cmd_t cmd;
    hisc_sts_t sts;

    hisc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd)
    );

    hisc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .coefficient_index (coefficient_index),
        .coefficient_value (coefficient_value),
        .src_x             (src_x),
        .src_y             (src_y),
        .dst_x             (dst_x),
        .dst_y             (dst_y),
        .last_pair         (last_pair),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .is_inlier         (is_inlier),
        .inlier_count      (inlier_count),
        .degenerate        (degenerate),
        .count_final       (count_final)
    );

endmodule

`default_nettype wire

// ===== sv/hisc_checker.sv =====
// Port-level checker of the inlier scoring core and its bind to the top level.
// Depends on homography_inlier_scoring_core_defines.svh.
`default_nettype none

`include "homography_inlier_scoring_core_defines.svh"

module hisc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        is_inlier,
    input wire logic [15:0] inlier_count,
    input wire logic        degenerate
);

    // A stalled result stays offered.
    `HISC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // An inlier and a degenerate pair exclude each other.
    `HISC_ASSERT_NOW(a_inl_degen, out_valid, !(is_inlier && degenerate))
    // An inlier always leaves a nonzero count.
    `HISC_ASSERT_NOW(a_inl_count, out_valid && is_inlier, inlier_count != 16'd0)
    // An accepted item cannot be followed by another in the next cycle.
    `HISC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind homography_inlier_scoring_core hisc_checker u_hisc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_inlier    (is_inlier),
    .inlier_count (inlier_count),
    .degenerate   (degenerate)
);

`default_nettype wire

// ===== verif/homography_inlier_scoring_core_test.sv =====
// Self-checking testbench of homography_inlier_scoring_core: directed and random load and
// test items, with scores predicted in the bench and compared with each result item.
// Depends on hisc_pkg and the core RTL.
`default_nettype none

module homography_inlier_scoring_core_test;
    import hisc_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [47:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic               operation;
    logic [3:0]         coefficient_index;
    logic signed [47:0] coefficient_value;
    logic signed [23:0] src_x;
    logic signed [23:0] src_y;
    logic signed [23:0] dst_x;
    logic signed [23:0] dst_y;
    logic               last_pair;
    logic               out_valid;
    logic               out_ready;
    logic               is_inlier;
    logic [15:0]        inlier_count;
    logic               degenerate;
    logic               count_final;

    typedef struct packed {
        logic        inlier;
        logic [15:0] count;
        logic        degen;
        logic        final_flag;
    } score_t;

    localparam logic [47:0] One = 48'h0001_0000_0000;
    localparam int unsigned StallLimit = 2000;

    score_t      pending_scores[$];
    logic [47:0] coef_shadow[NumCoef];
    logic [15:0] count_shadow;
    logic [47:0] tol_shadow;
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          no_idle;

    homography_inlier_scoring_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .coefficient_index(coefficient_index), .coefficient_value(coefficient_value),
        .src_x(src_x), .src_y(src_y), .dst_x(dst_x), .dst_y(dst_y),
        .last_pair(last_pair), .out_valid(out_valid), .out_ready(out_ready),
        .is_inlier(is_inlier), .inlier_count(inlier_count), .degenerate(degenerate),
        .count_final(count_final)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] magnitude64(input logic signed [63:0] a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] coef_q23(input logic [47:0] raw);
        logic signed [63:0] r;
        r = {{25{raw[47]}}, raw[47:9]};
        return r;
    endfunction

    function automatic logic signed [63:0] divide_q8(input logic signed [63:0] num,
                                                     input logic signed [63:0] den);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        logic [63:0] r;
        logic        neg;
        mn = magnitude64(num);
        md = magnitude64(den);
        q = mn / md;
        r = mn % md;
        neg = (num < 0) != (den < 0);
        if (q >= 64'd16777216)
        begin
            q = 64'd1 << 32;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= md)
                begin
                    r = r - md;
                    q[0] = 1'b1;
                end
            end
        end
        if (neg)
        begin
            if (q > 64'd8388608)
                q = 64'd8388608;
            return -$signed(q);
        end
        if (q > 64'd8388607)
            q = 64'd8388607;
        return $signed(q);
    endfunction

    task automatic project_point(input logic signed [23:0] sx, input logic signed [23:0] sy,
                                 output logic signed [63:0] px, output logic signed [63:0] py,
                                 output logic w_zero);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] p[3];
        x = sx;
        y = sy;
        for (int r = 0; r < 3; r++)
            p[r] = coef_q23(coef_shadow[r*3]) * x + coef_q23(coef_shadow[r*3+1]) * y
                 + coef_q23(coef_shadow[r*3+2]) * 64'sd256;
        w_zero = (p[2] == 0);
        px = 0;
        py = 0;
        if (!w_zero)
        begin
            px = divide_q8(p[0], p[2]);
            py = divide_q8(p[1], p[2]);
        end
    endtask

    task automatic score_item();
        score_t             s;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] ex;
        logic signed [63:0] ey;
        logic [63:0]        d2;
        logic               wz;
        s = '0;
        if (operation == OpLoad)
        begin
            if (coefficient_index < NumCoef)
                coef_shadow[coefficient_index] = coefficient_value;
            count_shadow = '0;
        end
        else
        begin
            s.final_flag = last_pair;
            project_point(src_x, src_y, px, py, wz);
            if (wz)
            begin
                s.degen = 1'b1;
            end
            else
            begin
                ex = px - 64'(dst_x);
                ey = py - 64'(dst_y);
                d2 = magnitude64(ex) * magnitude64(ex) + magnitude64(ey) * magnitude64(ey);
                if (d2 <= {16'd0, tol_shadow})
                begin
                    s.inlier = 1'b1;
                    if (count_shadow != 16'hFFFF)
                        count_shadow = count_shadow + 16'd1;
                end
            end
        end
        s.count = count_shadow;
        pending_scores.push_back(s);
    endtask

    function automatic logic [23:0] rand24();
        return 24'($urandom);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic signed [47:0] rand_near(input int span);
        return 48'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_item(input logic op, input logic [3:0] idx, input logic [47:0] val,
                             input logic [23:0] sx, input logic [23:0] sy,
                             input logic [23:0] dx, input logic [23:0] dy,
                             input logic lp);
        int unsigned gap;
        @(negedge clk);
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation <= op;
        coefficient_index <= idx;
        coefficient_value <= val;
        src_x <= sx;
        src_y <= sy;
        dst_x <= dx;
        dst_y <= dy;
        last_pair <= lp;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        score_item();
    endtask

    task automatic load_coef(input logic [3:0] idx, input logic [47:0] val);
        send_item(OpLoad, idx, val, rand24(), rand24(), rand24(), rand24(),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic test_pair(input logic [23:0] sx, input logic [23:0] sy,
                             input logic [23:0] dx, input logic [23:0] dy, input logic lp);
        send_item(OpTest, 4'($urandom_range(0, 15)), rand48(), sx, sy, dx, dy, lp);
    endtask

    task automatic write_tolerance(input logic [47:0] tol);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= tol;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= rand48();
        tol_shadow = tol;
    endtask

    task automatic load_near_identity();
        load_coef(0, One + rand_near(1 << 24));
        load_coef(1, rand_near(1 << 24));
        load_coef(2, rand_near(1 << 24) <<< 16);
        load_coef(3, rand_near(1 << 24));
        load_coef(4, One + rand_near(1 << 24));
        load_coef(5, rand_near(1 << 24) <<< 16);
        load_coef(6, rand_near(1 << 12));
        load_coef(7, rand_near(1 << 12));
        load_coef(8, One + rand_near(1 << 20));
    endtask

    task automatic test_near_pair(input int pspan, input int noise);
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic               wz;
        sx = 24'(int'($urandom_range(0, 2 * pspan)) - pspan);
        sy = 24'(int'($urandom_range(0, 2 * pspan)) - pspan);
        project_point(sx, sy, px, py, wz);
        test_pair(sx, sy, 24'(px + rand_near(noise)), 24'(py + rand_near(noise)),
                  $urandom_range(0, 3) == 0);
    endtask

    task automatic test_loads_and_index();
        load_coef(0, 48'h7FFF_FFFF_FFFF);
        load_coef(4, 48'h8000_0000_0000);
        for (int i = 9; i < 16; i++)
            load_coef(4'(i), rand48());
        for (int i = 0; i < NumCoef; i++)
            load_coef(4'(i), 48'd0);
    endtask

    task automatic test_identity_pairs();
        write_tolerance(48'hFFFF_FFFF_FFFF);
        load_coef(0, One);
        load_coef(4, One);
        load_coef(8, One);
        test_pair(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 1'b0);
        test_pair(24'h000100, 24'hFFFF00, 24'h000100, 24'hFFFF00, 1'b1);
        write_tolerance(48'd0);
        test_pair(24'h001234, 24'h004321, 24'h001234, 24'h004321, 1'b0);
        test_pair(24'h001234, 24'h004321, 24'h001235, 24'h004321, 1'b1);
    endtask

    task automatic test_degenerate_and_saturation();
        write_tolerance(48'h0000_0010_0000);
        load_coef(8, 48'd0);
        test_pair(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b0);
        test_pair(24'h7FFFFF, 24'h7FFFFF, 24'h000000, 24'h000000, 1'b1);
        load_coef(0, 48'h7FFF_FFFF_FFFF);
        load_coef(4, 48'h8000_0000_0000);
        load_coef(8, 48'h0000_0000_0200);
        test_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b0);
        test_pair(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 1'b1);
    endtask

    task automatic test_random_passes();
        int unsigned sent;
        sent = 0;
        while (sent < 610)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 3))
                0: write_tolerance(48'hFFFF_FFFF_FFFF);
                1: write_tolerance(rand48());
                default: write_tolerance(48'($urandom_range(0, 1 << 22)));
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                for (int i = 0; i < 12; i++)
                begin
                    if ($urandom_range(0, 1))
                        load_coef(4'($urandom_range(0, 15)), rand48());
                    else
                        test_pair(rand24(), rand24(), rand24(), rand24(),
                                  1'($urandom_range(0, 1)));
                end
                sent += 12;
            end
            else
            begin
                load_near_identity();
                for (int i = 0; i < 30; i++)
                    test_near_pair($urandom_range(0, 1) ? (1 << 16) : (1 << 22), 1024);
                sent += 39;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int unsigned gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        score_t exp_s;
        score_t got_s;
        if (rst_n && out_valid && out_ready)
        begin
            got_s = '{is_inlier, inlier_count, degenerate, count_final};
            if (pending_scores.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %p", got_s);
            end
            else
            begin
                exp_s = pending_scores.pop_front();
                if (got_s !== exp_s)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, actual %p", exp_s, got_s);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        operation = OpLoad;
        coefficient_index = '0;
        coefficient_value = '0;
        src_x = '0;
        src_y = '0;
        dst_x = '0;
        dst_y = '0;
        last_pair = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        count_shadow = '0;
        tol_shadow = '0;
        for (int i = 0; i < NumCoef; i++)
            coef_shadow[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_loads_and_index();
        test_identity_pairs();
        test_degenerate_and_saturation();
        test_random_passes();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
